### rtl/core/maa_pkg.sv
// Shared types, widths and codes of the mesh address allocator.
`default_nettype none

package maa_pkg;

   // field widths
   localparam int ADDR_W     = 16;
   localparam int ID_W       = 8;
   localparam int MC_W       = 3;
   localparam int DIGIT_BITS = 3;
   localparam int STATUS_W   = 3;
   localparam int OP_W       = 2;

   // candidate slots: child digits 1 .. max_children (max_children+1 at the root)
   localparam int NCAND      = 2 ** MC_W;
   localparam int SEL_W      = $clog2(NCAND);
   localparam int MAX_DIGITS = (ADDR_W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int SHIFT_W    = $clog2(DIGIT_BITS * MAX_DIGITS + 1);

   // stream payload widths
   localparam int REQ_W = 48;
   localparam int RSP_W = 40;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_IDX_DEFAULT_ADDR = 1'b0;
   localparam logic CSR_IDX_MAX_CHILDREN = 1'b1;

   localparam logic [ADDR_W-1:0] DEFAULT_ADDR_RESET = 16'd2340;
   localparam logic [MC_W-1:0]   MAX_CHILDREN_RESET = 3'd4;
   localparam int                TABLE_ENTRIES_DEF  = 32;

   typedef enum logic [OP_W-1:0] {
      OP_REQUEST  = 2'd0,
      OP_SET      = 2'd1,
      OP_REL_ADDR = 2'd2,
      OP_REL_ID   = 2'd3
   } opcode_type;

   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ID_ZERO   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] address;
      logic              confirmed;
   } entry_type;

   // results of one table walk
   typedef struct packed {
      logic [NCAND-1:0] hit;      // candidate held by some entry
      logic [NCAND-1:0] own;      // first holder has the requester's id
      logic             id_hit;   // requester id present
      logic             id_conf;  // confirmed flag of that entry
      logic [ID_W-1:0]  a0_id;    // id of first holder of slot 0
      logic             a0_conf;  // confirmed flag of that entry
   } match_flags_type;

endpackage

`default_nettype wire

### rtl/core/maa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module maa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/maa_match.sv
// Compare unit: checks one table entry per cycle against all keys and keeps first hits.
`default_nettype none

module maa_match #(
   parameter int TABLE_ENTRIES = maa_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   clear,
   input  wire logic                                   ent_valid,
   input  wire maa_pkg::entry_type                     ent,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0]       ent_idx,
   input  wire logic [maa_pkg::ID_W-1:0]               req_id,
   input  wire logic [maa_pkg::NCAND-1:0][maa_pkg::ADDR_W-1:0] cand,
   input  wire logic [maa_pkg::NCAND-1:0]              cand_en,
   output maa_pkg::match_flags_type                    flags,
   output logic      [$clog2(TABLE_ENTRIES)-1:0]       id_idx,
   output logic      [$clog2(TABLE_ENTRIES)-1:0]       a0_idx
);

   localparam int AW = $clog2(TABLE_ENTRIES);

   maa_pkg::match_flags_type flags_ff, flags_in;
   logic [AW-1:0] id_idx_ff, id_idx_in;
   logic [AW-1:0] a0_idx_ff, a0_idx_in;

   always_comb begin
      flags_in  = flags_ff;
      id_idx_in = id_idx_ff;
      a0_idx_in = a0_idx_ff;
      if (clear) begin
         flags_in.hit    = '0;
         flags_in.own    = '0;
         flags_in.id_hit = 1'b0;
      end else if (ent_valid) begin
         for (int j = 0; j < maa_pkg::NCAND; j++) begin
            // keep only the first entry that holds each key
            if (cand_en[j] && !flags_ff.hit[j] && ent.address == cand[j]) begin
               flags_in.hit[j] = 1'b1;
               flags_in.own[j] = (ent.id == req_id);
               if (j == 0) begin
                  a0_idx_in        = ent_idx;
                  flags_in.a0_id   = ent.id;
                  flags_in.a0_conf = ent.confirmed;
               end
            end
         end
         if (!flags_ff.id_hit && ent.id == req_id) begin
            flags_in.id_hit  = 1'b1;
            flags_in.id_conf = ent.confirmed;
            id_idx_in        = ent_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.hit    <= '0;
         flags_ff.own    <= '0;
         flags_ff.id_hit <= 1'b0;
      end else begin
         flags_ff <= flags_in;
      end
      id_idx_ff <= id_idx_in;
      a0_idx_ff <= a0_idx_in;
   end

   assign flags  = flags_ff;
   assign id_idx = id_idx_ff;
   assign a0_idx = a0_idx_ff;

endmodule

`default_nettype wire

### rtl/core/mesh_address_allocator.sv
// Top level of the mesh address allocator: channels, sequencer, table and registers.
//
// Usage:
//   req_*  : one request per handshake. req_tuser carries the opcode (address request,
//            set, release by address, release by id); req_tdata the node id, the
//            forwarding address, the target address and the confirmed flag.
//   rsp_*  : exactly one response per request, in order: status, granted address,
//            reply destination, send-reply and direct-send flags.
//   csr_*  : APB-style port, default_address at 0x0, max_children at 0x4.
//            Write only while no request is in flight.
// Sequence: a request passes the prepare, walk and decide states; the walk covers entries_used entries.
// Walk: requests are handled one at a time; the table walk reads one entry per cycle
//   from the single RAM read port and feeds it to the shared compare unit, which checks
//   it against all candidate addresses and the node id at once. req_tready is high only
//   in the idle state.
// Reset: the table is empty and the registers hold their reset values; entries of
//   the RAM are never compared before they are written, so it needs no clearing pass.
// Stall: a finished response waits in the output register; while rsp_tready is low
//   the sequencer holds the decision and the table update until the register frees.
`default_nettype none

module mesh_address_allocator #(
   parameter int TABLE_ENTRIES = maa_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [maa_pkg::REQ_W-1:0]   req_tdata,  // node_id, from_address,
                                                        // target_address, confirmed
   input  wire logic [maa_pkg::OP_W-1:0]    req_tuser,  // opcode
   // response channel
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [maa_pkg::RSP_W-1:0]   rsp_tdata,  // status, assigned_address,
                                                        // reply_to, send_reply, direct_send
   // configuration port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [maa_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [maa_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [maa_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int AD = maa_pkg::ADDR_W;
   localparam int EW = $bits(maa_pkg::entry_type);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_PREP   = 4'b0010,
      S_WALK   = 4'b0100,
      S_DECIDE = 4'b1000
   } state_type;

   // ---------------------------------------------------------------- registers
   state_type state_ff, state_in;

   logic [AD-1:0]               def_ff, def_in;
   logic [maa_pkg::MC_W-1:0]    mc_ff, mc_in;

   maa_pkg::opcode_type         op_ff, op_in;
   logic [maa_pkg::ID_W-1:0]    id_ff, id_in;
   logic [AD-1:0]               from_ff, from_in;
   logic [AD-1:0]               target_ff, target_in;
   logic                        conf_ff, conf_in;

   logic [maa_pkg::NCAND-1:0][AD-1:0] cand_ff, cand_in;
   logic [maa_pkg::NCAND-1:0]         cand_en_ff, cand_en_in;

   logic [CW-1:0]               used_ff, used_in;
   logic [CW-1:0]               walk_ff, walk_in;
   logic                        ent_valid_ff, ent_valid_in;
   logic [AW-1:0]               ent_idx_ff, ent_idx_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [maa_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- wires
   logic                        req_fire;
   logic                        csr_wr;
   logic                        fire;
   logic                        issue;
   logic                        from_default;
   logic [maa_pkg::SHIFT_W-1:0] shift_v;
   logic [maa_pkg::MC_W:0]      top_v;
   logic [AD-1:0]               base_v;
   logic [2*AD-1:0]             wide_v;

   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   maa_pkg::entry_type          ram_wdata;
   maa_pkg::entry_type          ram_rdata;

   maa_pkg::match_flags_type    flags;
   logic [AW-1:0]               id_idx;
   logic [AW-1:0]               a0_idx;

   logic                        found;
   logic [maa_pkg::SEL_W-1:0]   sel;
   logic                        has_room;
   logic [maa_pkg::STATUS_W-1:0] st_v;
   logic [AD-1:0]               assigned_v;
   logic [AD-1:0]               reply_v;
   logic                        send_v;
   logic                        direct_v;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign fire       = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_tready);
   assign issue      = (state_ff == S_WALK) && (walk_ff != used_ff);
   assign from_default = (from_ff == def_ff);
   assign has_room   = (used_ff != CW'(TABLE_ENTRIES));

   // ---------------------------------------------------------------- configuration
   always_comb begin
      def_in = def_ff;
      mc_in  = mc_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == maa_pkg::CSR_IDX_DEFAULT_ADDR) begin
            def_in = csr_pwdata[AD-1:0];
         end else begin
            mc_in = csr_pwdata[maa_pkg::MC_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == maa_pkg::CSR_IDX_MAX_CHILDREN) begin
         csr_prdata = {{(maa_pkg::CSR_DW - maa_pkg::MC_W){1'b0}}, mc_ff};
      end else begin
         csr_prdata = {{(maa_pkg::CSR_DW - AD){1'b0}}, def_ff};
      end
   end

   // ---------------------------------------------------------------- request capture
   always_comb begin
      op_in     = op_ff;
      id_in     = id_ff;
      from_in   = from_ff;
      target_in = target_ff;
      conf_in   = conf_ff;
      if (req_fire) begin
         op_in     = maa_pkg::opcode_type'(req_tuser);
         id_in     = req_tdata[7:0];
         from_in   = req_tdata[23:8];
         target_in = req_tdata[39:24];
         conf_in   = req_tdata[40];
      end
   end

   // ---------------------------------------------------------------- candidate setup
   // Count the octal digits of the forwarder to find where the child digit goes.
   always_comb begin
      shift_v = '0;
      for (int k = 0; k < maa_pkg::MAX_DIGITS; k++) begin
         if ((from_ff >> (maa_pkg::DIGIT_BITS * k)) != '0) begin
            shift_v = shift_v + maa_pkg::SHIFT_W'(maa_pkg::DIGIT_BITS);
         end
      end
   end

   always_comb begin
      // root children for an unassigned node, else children of the forwarder
      top_v  = from_default ? ({1'b0, mc_ff} + 1'b1) : {1'b0, mc_ff};
      base_v = from_default ? '0 : from_ff;
      wide_v = '0;
      cand_in    = cand_ff;
      cand_en_in = cand_en_ff;
      if (state_ff == S_PREP) begin
         for (int j = 0; j < maa_pkg::NCAND; j++) begin
            wide_v = {{AD{1'b0}}, base_v}
                   | ((2*AD)'(j + 1) << (from_default ? '0 : shift_v));
            cand_in[j]    = wide_v[AD-1:0];
            cand_en_in[j] = ((maa_pkg::MC_W + 1)'(j + 1) <= top_v)
                            && (wide_v[AD-1:0] != '0)
                            && (wide_v[AD-1:0] != def_ff);
         end
         case (op_ff)
            maa_pkg::OP_REQUEST: begin
            end
            maa_pkg::OP_REL_ADDR: begin
               // slot 0 carries the address to release, zero included
               cand_in[0]    = target_ff;
               cand_en_in    = '0;
               cand_en_in[0] = 1'b1;
            end
            default: begin
               cand_en_in = '0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- table walk
   always_comb begin
      walk_in      = walk_ff;
      ent_valid_in = issue;
      ent_idx_in   = walk_ff[AW-1:0];
      if (state_ff == S_PREP) begin
         walk_in = '0;
      end else if (issue) begin
         walk_in = walk_ff + 1'b1;
      end
   end

   maa_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (walk_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   maa_match #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .clear     (state_ff == S_PREP),
      .ent_valid (ent_valid_ff),
      .ent       (ram_rdata),
      .ent_idx   (ent_idx_ff),
      .req_id    (id_ff),
      .cand      (cand_ff),
      .cand_en   (cand_en_ff),
      .flags     (flags),
      .id_idx    (id_idx),
      .a0_idx    (a0_idx)
   );

   // ---------------------------------------------------------------- decision
   // Pick the highest usable child digit: free, or first held by the requester.
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int j = 0; j < maa_pkg::NCAND; j++) begin
         if (cand_en_ff[j] && (!flags.hit[j] || flags.own[j])) begin
            found = 1'b1;
            sel   = maa_pkg::SEL_W'(j);
         end
      end
   end

   always_comb begin
      st_v       = maa_pkg::ST_DONE;
      assigned_v = '0;
      reply_v    = '0;
      send_v     = 1'b0;
      direct_v   = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = id_idx;
      ram_wdata  = '{id: id_ff, address: target_ff, confirmed: conf_ff};
      used_in    = used_ff;
      case (op_ff)
         maa_pkg::OP_REQUEST: begin
            reply_v   = from_ff;
            ram_wdata = '{id: id_ff, address: cand_ff[sel], confirmed: 1'b0};
            if (id_ff == '0) begin
               st_v = maa_pkg::ST_ID_ZERO;
            end else if (!found) begin
               st_v = maa_pkg::ST_NO_FREE;
            end else if (!flags.id_hit && !has_room) begin
               st_v = maa_pkg::ST_FULL;
            end else begin
               assigned_v = cand_ff[sel];
               send_v     = 1'b1;
               direct_v   = from_default;
               ram_we     = fire;
               if (!flags.id_hit) begin
                  ram_waddr = used_ff[AW-1:0];
                  used_in   = fire ? used_ff + 1'b1 : used_ff;
               end
            end
         end
         maa_pkg::OP_SET: begin
            if (!flags.id_hit && !has_room) begin
               st_v = maa_pkg::ST_FULL;
            end else begin
               ram_we = fire;
               if (!flags.id_hit) begin
                  ram_waddr = used_ff[AW-1:0];
                  used_in   = fire ? used_ff + 1'b1 : used_ff;
               end
            end
         end
         maa_pkg::OP_REL_ADDR: begin
            ram_waddr = a0_idx;
            ram_wdata = '{id: flags.a0_id, address: '0, confirmed: flags.a0_conf};
            if (flags.hit[0]) begin
               ram_we = fire;
            end else begin
               st_v = maa_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            ram_wdata = '{id: id_ff, address: '0, confirmed: flags.id_conf};
            if (flags.id_hit) begin
               ram_we = fire;
            end else begin
               st_v = maa_pkg::ST_NOT_FOUND;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------- response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, direct_v, send_v, reply_v, assigned_v, st_v};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            // the last entry is compared in the cycle the walk index reaches the fill
            if (walk_ff == used_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         def_ff       <= maa_pkg::DEFAULT_ADDR_RESET;
         mc_ff        <= maa_pkg::MAX_CHILDREN_RESET;
         used_ff      <= '0;
         walk_ff      <= '0;
         ent_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         def_ff       <= def_in;
         mc_ff        <= mc_in;
         used_ff      <= used_in;
         walk_ff      <= walk_in;
         ent_valid_ff <= ent_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      id_ff       <= id_in;
      from_ff     <= from_in;
      target_ff   <= target_in;
      conf_ff     <= conf_in;
      cand_ff     <= cand_in;
      cand_en_ff  <= cand_en_in;
      ent_idx_ff  <= ent_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------- assertions
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(TABLE_ENTRIES))
      else $error("table fill count beyond table size");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && used_ff != $past(used_ff))
         |-> ($past(fire) && used_ff == $past(used_ff) + 1'b1))
      else $error("table fill count changed outside a response");

   a_entry_in_walk: assert property (@(posedge clock) disable iff (reset)
      ent_valid_ff |-> (state_ff == S_WALK))
      else $error("table entry compared outside the walk");

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == S_DECIDE))
      else $error("response raised without a decision");

endmodule

`default_nettype wire
